FILE: rtl/sfm_pkg.sv
// Shared types and codes for the substring first-match search block.
package sfm_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 16;
  localparam longint unsigned TEXT_MAX_DEF = 64'd65535;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W = 16;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_END     = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PAT_OVF  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TEXT_OVF = 2'd2;

  // Per-cycle controls broadcast to every cell of the compare row.
  typedef struct packed {
    logic clear_pat;   // drop the whole pattern
    logic load_pat;    // shift a pattern byte into the row
    logic shift_text;  // shift a text byte into the window
  } sfm_ctl_t;

endpackage

FILE: rtl/sfm_if.sv
// Request and result channel interfaces of the substring search block.
interface sfm_req_if
  import sfm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface sfm_res_if
  import sfm_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    match_position;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output match_position, output status, input ready);
  modport sink (input valid, input match_position, input status, output ready);
endinterface

FILE: rtl/sfm_cell.sv
// One cell of the compare row: a window byte, a pattern byte and an active flag.
module sfm_cell
  import sfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  sfm_ctl_t          ctl,
  input  logic [BYTE_W-1:0] pat_in,
  input  logic              act_in,
  input  logic [BYTE_W-1:0] win_in,
  output logic [BYTE_W-1:0] pat_out,
  output logic              act_out,
  output logic [BYTE_W-1:0] win_out,
  output logic              hit
);

  logic [BYTE_W-1:0] pat;
  logic              act;
  logic [BYTE_W-1:0] win;

  // active flag marks cells that lie inside the loaded pattern
  always_ff @(posedge clk) begin
    if (rst || ctl.clear_pat) begin
      act <= 1'b0;
    end else if (ctl.load_pat) begin
      act <= act_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_pat) begin
      pat <= pat_in;
    end
    if (ctl.shift_text) begin
      win <= win_in;
    end
  end

  // compare against the byte this cell will hold after the shift
  assign hit     = !act || (win_in == pat);
  assign pat_out = pat;
  assign act_out = act;
  assign win_out = win;

endmodule

FILE: rtl/substring_first_match.sv
// Top level of the substring first-match search block.
// Finds the 1-based start of the first occurrence of a pattern in a text
// stream. A clear request empties the pattern; pattern-byte requests load
// it (up to PATTERN_MAX bytes, more sets the pattern overflow status);
// text-byte requests stream text; an end-of-text request returns one
// result (position, status) and restarts the text while keeping the
// pattern. Position 0 means no match, an empty pattern reports 1, and
// positions are reported modulo 2^16. Text bytes past TEXT_MAX are dropped
// and flagged with status 2; status 1 wins when both flags are set.
// Throughput is one request per clock of any kind. The result of an
// end-of-text request appears in the cycle after it is accepted, held in an
// output register, so the block keeps taking requests while a result waits
// (it stalls only if a second result would overwrite an untaken one). The
// compare row is combinational: each cell checks the byte
// about to enter its window slot against its pattern byte, and the row's
// hits are ANDed in the same cycle. No clearing pass after reset.
module substring_first_match
  import sfm_pkg::*;
#(
  parameter int unsigned      PATTERN_MAX = PATTERN_MAX_DEF,
  parameter longint unsigned  TEXT_MAX    = TEXT_MAX_DEF
) (
  input logic      clk,
  input logic      rst,
  sfm_req_if.sink  req,
  sfm_res_if.source rsp
);

  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int unsigned CNT_W = $clog2(TEXT_MAX + 64'd1);
  localparam int unsigned EXT_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // search state
  logic [LEN_W-1:0] plen;
  logic             pat_ovf;
  logic [CNT_W-1:0] count;
  logic             found;
  logic [POS_W-1:0] first;
  logic             text_ovf;

  // output register
  logic                res_valid;
  logic [POS_W-1:0]    res_pos;
  logic [STATUS_W-1:0] res_status;

  logic accept;
  logic text_full;
  logic pat_room;
  logic row_hit;
  logic [CNT_W-1:0] count_next;
  logic [EXT_W-1:0] pos_ext;
  logic take_match;
  sfm_ctl_t ctl;

  // row wiring: index 0 faces the input, higher cells hold older bytes
  logic [BYTE_W-1:0] pat_chain [PATTERN_MAX+1];
  logic              act_chain [PATTERN_MAX+1];
  logic [BYTE_W-1:0] win_chain [PATTERN_MAX+1];
  logic [PATTERN_MAX-1:0] hits;

  assign accept    = req.valid && req.ready;
  // only an end-of-text request waits on an untaken result
  assign req.ready = !res_valid || rsp.ready || (req.command != CMD_END);

  assign text_full  = (count >= CNT_W'(TEXT_MAX));
  assign pat_room   = (plen < LEN_W'(PATTERN_MAX));
  assign count_next = count + CNT_W'(1);

  always_comb begin
    ctl            = '0;
    ctl.clear_pat  = accept && (req.command == CMD_CLEAR);
    ctl.load_pat   = accept && (req.command == CMD_PATTERN) && pat_room;
    ctl.shift_text = accept && (req.command == CMD_TEXT) && !text_full;
  end

  assign pat_chain[0] = req.data_byte;
  assign act_chain[0] = 1'b1;
  assign win_chain[0] = req.data_byte;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    sfm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .pat_in  (pat_chain[i]),
      .act_in  (act_chain[i]),
      .win_in  (win_chain[i]),
      .pat_out (pat_chain[i+1]),
      .act_out (act_chain[i+1]),
      .win_out (win_chain[i+1]),
      .hit     (hits[i])
    );
  end

  assign row_hit = &hits;

  // start position of a match ending at the byte being taken
  assign pos_ext = EXT_W'(count_next) - EXT_W'(plen) + EXT_W'(1);

  // only a full window of fresh text may match
  assign take_match = ctl.shift_text && row_hit && !pat_ovf && (plen != '0) && !found &&
                      (EXT_W'(count_next) >= EXT_W'(plen));

  always_ff @(posedge clk) begin
    if (rst) begin
      plen     <= '0;
      pat_ovf  <= 1'b0;
      count    <= '0;
      found    <= 1'b0;
      text_ovf <= 1'b0;
    end else if (accept) begin
      case (req.command)
        CMD_CLEAR: begin
          plen     <= '0;
          pat_ovf  <= 1'b0;
          count    <= '0;
          found    <= 1'b0;
          text_ovf <= 1'b0;
        end
        CMD_PATTERN: begin
          if (pat_room) begin
            plen <= plen + LEN_W'(1);
          end else begin
            pat_ovf <= 1'b1;
          end
          count    <= '0;
          found    <= 1'b0;
          text_ovf <= 1'b0;
        end
        CMD_TEXT: begin
          if (text_full) begin
            text_ovf <= 1'b1;
          end else begin
            count <= count_next;
            if (take_match) begin
              found <= 1'b1;
            end
          end
        end
        default: begin
          // end of text: result goes out, text side restarts
          count    <= '0;
          found    <= 1'b0;
          text_ovf <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take_match) begin
      first <= pos_ext[POS_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && (req.command == CMD_END)) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req.command == CMD_END)) begin
      if (pat_ovf) begin
        res_pos <= '0;
      end else if (plen == '0) begin
        res_pos <= POS_W'(1);
      end else if (found) begin
        res_pos <= first;
      end else begin
        res_pos <= '0;
      end
      if (pat_ovf) begin
        res_status <= STATUS_PAT_OVF;
      end else if (text_ovf) begin
        res_status <= STATUS_TEXT_OVF;
      end else begin
        res_status <= STATUS_OK;
      end
    end
  end

  assign rsp.valid          = res_valid;
  assign rsp.match_position = res_pos;
  assign rsp.status         = res_status;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the substring first-match search block.
`timescale 1ns / 100ps

module tb_top;
  import sfm_pkg::*;

  localparam int unsigned     PAT_MAX = PATTERN_MAX_DEF;
  localparam longint unsigned TXT_MAX = TEXT_MAX_DEF;

  // One search result as the block reports it.
  typedef struct packed {
    logic [POS_W-1:0]    pos;
    logic [STATUS_W-1:0] st;
  } match_res_t;

  // Directed request row; typed rows carry a hand-written expected result.
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [BYTE_W-1:0]   b;
    logic                typed;
    logic [POS_W-1:0]    pos;
    logic [STATUS_W-1:0] st;
  } dir_row_t;

  // Directed requests: empty pattern with and without text, byte extremes,
  // a zero-filled window that must not fake a match before enough text has
  // arrived, a later second occurrence that must not replace the first,
  // pattern growth restarting the text, and clear with ignored data bytes.
  dir_row_t dir_rows [25] = '{
    '{CMD_END,     8'h00, 1'b1, 16'd1, STATUS_OK},  // empty pattern, empty text
    '{CMD_TEXT,    8'h00, 1'b0, 16'd0, STATUS_OK},
    '{CMD_TEXT,    8'hFF, 1'b0, 16'd0, STATUS_OK},
    '{CMD_END,     8'hFF, 1'b1, 16'd1, STATUS_OK},  // empty pattern, some text
    '{CMD_PATTERN, 8'h00, 1'b0, 16'd0, STATUS_OK},
    '{CMD_PATTERN, 8'hFF, 1'b0, 16'd0, STATUS_OK},
    '{CMD_TEXT,    8'hFF, 1'b0, 16'd0, STATUS_OK},
    '{CMD_END,     8'h00, 1'b1, 16'd0, STATUS_OK},  // window zeros must not match
    '{CMD_TEXT,    8'hFF, 1'b0, 16'd0, STATUS_OK},
    '{CMD_TEXT,    8'h00, 1'b0, 16'd0, STATUS_OK},
    '{CMD_TEXT,    8'hFF, 1'b0, 16'd0, STATUS_OK},
    '{CMD_TEXT,    8'h00, 1'b0, 16'd0, STATUS_OK},
    '{CMD_TEXT,    8'hFF, 1'b0, 16'd0, STATUS_OK},
    '{CMD_END,     8'h00, 1'b0, 16'd0, STATUS_OK},
    '{CMD_PATTERN, 8'h5A, 1'b0, 16'd0, STATUS_OK},
    '{CMD_TEXT,    8'h00, 1'b0, 16'd0, STATUS_OK},
    '{CMD_TEXT,    8'hFF, 1'b0, 16'd0, STATUS_OK},
    '{CMD_TEXT,    8'h5A, 1'b0, 16'd0, STATUS_OK},
    '{CMD_PATTERN, 8'hA5, 1'b0, 16'd0, STATUS_OK},  // drops the match just found
    '{CMD_END,     8'h00, 1'b0, 16'd0, STATUS_OK},
    '{CMD_CLEAR,   8'h00, 1'b0, 16'd0, STATUS_OK},
    '{CMD_TEXT,    8'h3C, 1'b0, 16'd0, STATUS_OK},
    '{CMD_END,     8'h00, 1'b1, 16'd1, STATUS_OK},  // empty again after clear
    '{CMD_CLEAR,   8'hFF, 1'b0, 16'd0, STATUS_OK},
    '{CMD_END,     8'hAB, 1'b1, 16'd1, STATUS_OK}
  };

  logic clk = 1'b0;
  logic rst;

  sfm_req_if req_ch ();
  sfm_res_if rsp_ch ();

  substring_first_match #(
    .PATTERN_MAX (PAT_MAX),
    .TEXT_MAX    (TXT_MAX)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // Shadow of the search state, advanced on every accepted request.
  logic [BYTE_W-1:0] pat_bytes [PAT_MAX];
  int unsigned       pat_len;
  bit                pat_ovf;
  logic [BYTE_W-1:0] win [PAT_MAX];   // entry 0 is the newest text byte
  longint unsigned   txt_cnt;
  longint unsigned   first_pos;
  bit                txt_ovf;

  match_res_t expected_matches [$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int pat_ovf_seen = 0;
  int txt_ovf_seen = 0;

  // Idle rates in percent per cycle; squeeze_tick asks the receiver for a
  // long hold-off.
  int snd_idle_pct = 31;
  int rcv_idle_pct = 66;
  int squeeze_tick = 0;

  function automatic void drop_text();
    foreach (win[k]) win[k] = '0;
    txt_cnt = 0;
    first_pos = 0;
    txt_ovf = 1'b0;
  endfunction

  // Next state of the search for one request; has_res tells whether the
  // request produces a result.
  function automatic void predict_search(input logic [CMD_W-1:0] cmd,
                                         input logic [BYTE_W-1:0] b,
                                         output bit has_res,
                                         output match_res_t res);
    bit hit;
    has_res = 1'b0;
    res = '0;
    case (cmd)
      CMD_CLEAR: begin
        pat_len = 0;
        pat_ovf = 1'b0;
        drop_text();
      end
      CMD_PATTERN: begin
        if (pat_len < PAT_MAX) begin
          pat_bytes[pat_len] = b;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
        drop_text();
      end
      CMD_TEXT: begin
        if (txt_cnt >= TXT_MAX) begin
          txt_ovf = 1'b1;
        end else begin
          for (int k = PAT_MAX - 1; k > 0; k--) win[k] = win[k-1];
          win[0] = b;
          txt_cnt++;
          if (!pat_ovf && pat_len > 0 && first_pos == 0 && txt_cnt >= pat_len) begin
            hit = 1'b1;
            for (int j = 0; j < pat_len; j++)
              if (win[pat_len-1-j] != pat_bytes[j]) hit = 1'b0;
            if (hit) first_pos = txt_cnt - pat_len + 1;
          end
        end
      end
      default: begin
        has_res = 1'b1;
        if (pat_ovf) res.pos = '0;
        else if (pat_len == 0) res.pos = POS_W'(1);
        else res.pos = first_pos[POS_W-1:0];
        if (pat_ovf) res.st = STATUS_PAT_OVF;
        else if (txt_ovf) res.st = STATUS_TEXT_OVF;
        else res.st = STATUS_OK;
        drop_text();
      end
    endcase
  endfunction

  // Offer one request after a random gap, wait for the handshake, then
  // record what the block should answer.
  task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
    int gap;
    bit has_res;
    match_res_t res;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.command   <= cmd;
    req_ch.data_byte <= b;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    predict_search(cmd, b, has_res, res);
    if (has_res) expected_matches.push_back(res);
    items_sent++;
  endtask

  // Result side: check every accepted result against the oldest expected
  // one, then pick ready for the next cycle. A hold-off request drops
  // ready for a counted stretch so the output register stays full and the
  // block has to stall its request side.
  initial begin
    int hold_left;
    int seen_tick;
    match_res_t want;
    rsp_ch.ready = 1'b0;
    hold_left = 0;
    seen_tick = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
        results_seen++;
        if (expected_matches.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: match_position %0d status %0d", $time,
                   rsp_ch.match_position, rsp_ch.status);
        end else begin
          want = expected_matches.pop_front();
          if (rsp_ch.match_position !== want.pos) begin
            errors++;
            $display("%0t: match_position expected %0d got %0d", $time, want.pos,
                     rsp_ch.match_position);
          end
          if (rsp_ch.status !== want.st) begin
            errors++;
            $display("%0t: status expected %0d got %0d", $time, want.st, rsp_ch.status);
          end
          if (want.st == STATUS_PAT_OVF) pat_ovf_seen++;
          else if (want.st == STATUS_TEXT_OVF) txt_ovf_seen++;
          if (want.pos > 1) hits_seen++;
        end
      end
      if (squeeze_tick != seen_tick) begin
        seen_tick = squeeze_tick;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Stimulus: directed table, then random search rounds in three idle
  // phases.
  initial begin
    int phase;
    int plen;
    int tlen;
    int at;
    int roll;
    int n;
    bit squeezed;
    logic [BYTE_W-1:0] sym0;
    logic [BYTE_W-1:0] sym1;
    logic [BYTE_W-1:0] pat [20];
    logic [BYTE_W-1:0] txt [64];

    rst = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.command   = CMD_CLEAR;
    req_ch.data_byte = '0;
    foreach (pat_bytes[k]) pat_bytes[k] = '0;
    pat_len = 0;
    pat_ovf = 1'b0;
    drop_text();
    phase = 0;
    squeezed = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].cmd, dir_rows[i].b);
      if (dir_rows[i].typed) expected_matches[$] = {dir_rows[i].pos, dir_rows[i].st};
    end

    while (items_sent < 1950) begin
      // idle phases: sender-light, then receiver-light, then none
      if (items_sent >= 1300 && phase != 2) begin
        phase = 2;
        snd_idle_pct <= 0;
        rcv_idle_pct <= 0;
      end else if (items_sent >= 650 && phase == 0) begin
        phase = 1;
        snd_idle_pct <= 66;
        rcv_idle_pct <= 31;
      end

      // Back-pressure burst: many short texts while the receiver holds off.
      if (phase == 2 && !squeezed) begin
        squeezed = 1'b1;
        squeeze_tick <= squeeze_tick + 1;
        send_req(CMD_CLEAR, 8'($urandom));
        repeat (12) begin
          send_req(CMD_TEXT, 8'($urandom));
          send_req(CMD_END, 8'($urandom));
        end
      end

      roll = $urandom_range(99);
      if (roll < 8) begin
        // noise: arbitrary requests
        repeat ($urandom_range(4, 1))
          send_req(CMD_W'($urandom_range(CMD_END)), 8'($urandom));
      end else begin
        // well-formed round: clear, pattern, one to three texts, each closed
        // by an end request; now and then clear, end or order is broken
        if ($urandom_range(9) != 0) send_req(CMD_CLEAR, 8'($urandom));
        roll = $urandom_range(99);
        if (roll < 6) plen = 0;
        else if (roll < 70) plen = $urandom_range(4, 1);
        else if (roll < 88) plen = $urandom_range(15, 5);
        else if (roll < 94) plen = PAT_MAX;
        else plen = $urandom_range(PAT_MAX + 3, PAT_MAX + 1);

        // two-symbol alphabet so that matches are common
        sym0 = 8'($urandom);
        sym1 = 8'($urandom);
        for (int i = 0; i < plen; i++) begin
          if ($urandom_range(7) == 0) pat[i] = 8'($urandom);
          else pat[i] = $urandom_range(1) ? sym0 : sym1;
          send_req(CMD_PATTERN, pat[i]);
        end

        repeat ($urandom_range(3, 1)) begin
          tlen = ($urandom_range(9) == 0) ? $urandom_range(60, 41) : $urandom_range(40);
          for (int i = 0; i < tlen; i++) begin
            if ($urandom_range(9) == 0) txt[i] = 8'($urandom);
            else txt[i] = $urandom_range(1) ? sym0 : sym1;
          end
          // plant the pattern somewhere in half the texts
          if (plen > 0 && plen <= PAT_MAX && tlen >= plen && $urandom_range(1)) begin
            at = $urandom_range(tlen - plen);
            for (int i = 0; i < plen; i++) txt[at+i] = pat[i];
          end
          for (int i = 0; i < tlen; i++) begin
            if ($urandom_range(199) == 0) send_req(CMD_PATTERN, 8'($urandom));
            send_req(CMD_TEXT, txt[i]);
          end
          if ($urandom_range(19) != 0) send_req(CMD_END, 8'($urandom));
        end
      end
    end

    req_ch.valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    n = 0;
    while (n < 20) begin
      @(posedge clk);
      n++;
    end

    $display("tb_top: %0d requests sent, %0d results checked", items_sent, results_seen);
    $display("tb_top: %0d matches past position 1, %0d pattern and %0d text overflows",
             hits_seen, pat_ovf_seen, txt_ovf_seen);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Hang guard: several times the slowest expected run.
  initial begin
    #8_000_000;
    $display("tb_top: timeout with %0d results outstanding", expected_matches.size());
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
rtl/sfm_pkg.sv
rtl/sfm_if.sv
rtl/sfm_cell.sv
rtl/substring_first_match.sv
test/tb_top.sv
